[src/msseq_pkg.sv]
// shared constants, types and lookup functions for the melody score sequencer
package msseq_pkg;

    localparam int SCORE_DEPTH = 256;
    localparam int NOTE_COUNT  = 26;
    localparam int SCORE_AW    = $clog2(SCORE_DEPTH);
    // wide enough for start + position before the address wraps
    localparam int SUM_W       = (SCORE_AW > 10) ? SCORE_AW : 10;

    // event codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_PLAY    = 3'd2;
    localparam logic [2:0] OP_SLOWER  = 3'd3;
    localparam logic [2:0] OP_FASTER  = 3'd4;
    localparam logic [2:0] OP_SONG_A  = 3'd5;
    localparam logic [2:0] OP_SONG_B  = 3'd6;
    localparam logic [2:0] OP_WRITE   = 3'd7;

    // player status codes
    localparam logic [1:0] ST_PLAY  = 2'd0;
    localparam logic [1:0] ST_PAUSE = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_A_START   = 3'd0;
    localparam logic [2:0] CFG_A_LEN     = 3'd1;
    localparam logic [2:0] CFG_B_START   = 3'd2;
    localparam logic [2:0] CFG_B_LEN     = 3'd3;
    localparam logic [2:0] CFG_DEF_TEMPO = 3'd4;
    localparam logic [2:0] CFG_FLASH     = 3'd5;

    localparam logic [6:0]  TEMPO_MAX = 7'd88;
    localparam logic [6:0]  TEMPO_MIN = 7'd1;
    localparam logic [10:0] TICK_MAX  = 11'd2047;

    localparam logic [10:0] HALF_PERIODS [32] = '{
        11'd1,    11'd1911, 11'd1803, 11'd1703, 11'd1607, 11'd1517, 11'd1432, 11'd1351,
        11'd1276, 11'd1204, 11'd1136, 11'd1073, 11'd1012, 11'd956,  11'd902,  11'd851,
        11'd803,  11'd758,  11'd716,  11'd676,  11'd638,  11'd602,  11'd568,  11'd536,
        11'd506,  11'd478,  11'd1,    11'd1,    11'd1,    11'd1,    11'd1,    11'd1
    };

    localparam logic [6:0] DUR_TICKS [8] = '{
        7'd1, 7'd8, 7'd16, 7'd24, 7'd32, 7'd48, 7'd64, 7'd96
    };

    typedef struct packed {
        logic [7:0] a_start;
        logic [8:0] a_len;
        logic [7:0] b_start;
        logic [8:0] b_len;
        logic [6:0] def_tempo;
        logic [7:0] flash_ivl;
    } t_cfg;

    typedef struct packed {
        logic [10:0] period;
        logic        tone_on;
        logic        led_on;
        logic [1:0]  status;
    } t_result;

    // note indexes past the note table play as a rest
    function automatic logic [10:0] note_half_period(input logic [7:0] b);
        logic [4:0] idx;
        idx = b[4:0];
        if ({1'b0, idx} >= 6'(NOTE_COUNT)) begin
            idx = '0;
        end
        return HALF_PERIODS[idx];
    endfunction

    function automatic logic [6:0] dur_ticks(input logic [7:0] b);
        return DUR_TICKS[b[7:5]];
    endfunction

endpackage

[src/msseq_score_mem.sv]
// score memory: one write port, two registered read ports
module msseq_score_mem
    import msseq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [SCORE_AW-1:0] i_waddr,
    input  logic [7:0]          i_wdata,
    input  logic                i_re,
    input  logic [SCORE_AW-1:0] i_raddr0,
    input  logic [SCORE_AW-1:0] i_raddr1,
    output logic [7:0]          o_rdata0,
    output logic [7:0]          o_rdata1
);

    logic [7:0] r_mem [SCORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read so a stalled event keeps its bytes
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

[src/msseq_player.sv]
// player state registers, score read addressing and per-event state update
module msseq_player
    import msseq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic [2:0]          i_issue_op,
    input  logic                i_exec,
    input  logic [2:0]          i_exec_op,
    input  logic [7:0]          i_rdata0,
    input  logic [7:0]          i_rdata1,
    output logic [SCORE_AW-1:0] o_raddr0,
    output logic [SCORE_AW-1:0] o_raddr1,
    output t_result             o_result
);

    logic [1:0]  r_status, n_status;
    logic        r_sel, n_sel;
    logic [8:0]  r_pos, n_pos;
    logic [10:0] r_tick, n_tick;
    logic [6:0]  r_tempo, n_tempo;
    logic        r_brk, n_brk;
    logic [7:0]  r_flash, n_flash;
    logic        r_led, n_led;
    logic [10:0] r_period, n_period;

    logic [7:0]       w_cur_start;
    logic [7:0]       w_base;
    logic [8:0]       w_offs;
    logic [8:0]       w_next_pos;
    logic [SUM_W-1:0] w_sum0;
    logic [SUM_W-1:0] w_sum1;
    logic [8:0]       w_len;
    logic [13:0]      w_need;
    logic [13:0]      w_have;
    logic [10:0]      w_next_period;
    logic [10:0]      w_first_period;

    // read addressing for the event being accepted
    assign w_cur_start = r_sel ? i_cfg.b_start : i_cfg.a_start;
    assign w_next_pos  = r_pos + 9'd1;

    always_comb begin
        case (i_issue_op)
            OP_RESTART: begin
                w_base = w_cur_start;
                w_offs = '0;
            end
            OP_SONG_A: begin
                w_base = i_cfg.a_start;
                w_offs = '0;
            end
            OP_SONG_B: begin
                w_base = i_cfg.b_start;
                w_offs = '0;
            end
            default: begin
                w_base = w_cur_start;
                w_offs = r_pos;
            end
        endcase
    end

    assign w_sum0   = SUM_W'(w_base) + SUM_W'(w_offs);
    assign w_sum1   = SUM_W'(w_cur_start) + SUM_W'(w_next_pos);
    assign o_raddr0 = w_sum0[SCORE_AW-1:0];
    assign o_raddr1 = w_sum1[SCORE_AW-1:0];

    // update for the event whose score bytes are now read
    assign w_len          = r_sel ? i_cfg.b_len : i_cfg.a_len;
    assign w_need         = 14'(dur_ticks(i_rdata0)) * 14'(r_tempo);
    assign w_have         = {r_tick, 3'b000};
    assign w_next_period  = note_half_period(i_rdata1);
    assign w_first_period = note_half_period(i_rdata0) - 11'd1;

    always_comb begin
        n_status = r_status;
        n_sel    = r_sel;
        n_pos    = r_pos;
        n_tick   = r_tick;
        n_tempo  = r_tempo;
        n_brk    = r_brk;
        n_flash  = r_flash;
        n_led    = r_led;
        n_period = r_period;
        if (i_exec) begin
            case (i_exec_op)
                OP_TICK: begin
                    if (r_status == ST_PLAY) begin
                        if (r_pos < w_len) begin
                            if (!r_brk && (w_have < w_need)) begin
                                if (r_tick != TICK_MAX) begin
                                    n_tick = r_tick + 11'd1;
                                end
                            end else begin
                                // step to the next note; lookup skipped past song end
                                n_tick = '0;
                                n_pos  = w_next_pos;
                                n_brk  = 1'b0;
                                if (w_next_pos < w_len) begin
                                    n_period = w_next_period;
                                    n_brk    = !r_brk && (i_rdata1[7:5] == 3'd0);
                                end
                            end
                        end else begin
                            n_status = ST_DONE;
                            n_led    = 1'b1;
                        end
                    end else if (r_status == ST_PAUSE) begin
                        if (r_flash == i_cfg.flash_ivl) begin
                            n_flash = '0;
                            n_led   = !r_led;
                        end else begin
                            n_flash = r_flash + 8'd1;
                        end
                    end
                end
                OP_RESTART, OP_SONG_A, OP_SONG_B: begin
                    if (i_exec_op == OP_SONG_A) begin
                        n_sel = 1'b0;
                    end else if (i_exec_op == OP_SONG_B) begin
                        n_sel = 1'b1;
                    end
                    n_tick   = '0;
                    n_pos    = '0;
                    n_tempo  = i_cfg.def_tempo;
                    n_brk    = 1'b0;
                    n_status = ST_READY;
                    n_period = w_first_period;
                    n_led    = 1'b1;
                end
                OP_PLAY: begin
                    if (r_status != ST_DONE) begin
                        if (r_status == ST_PLAY) begin
                            n_status = ST_PAUSE;
                        end else begin
                            n_status = ST_PLAY;
                            n_led    = 1'b0;
                        end
                    end
                end
                OP_SLOWER: begin
                    if (r_tempo < TEMPO_MAX) begin
                        n_tempo = r_tempo + 7'd1;
                    end
                end
                OP_FASTER: begin
                    if (r_tempo > TEMPO_MIN) begin
                        n_tempo = r_tempo - 7'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_READY;
            r_sel    <= 1'b0;
            r_pos    <= '0;
            r_tick   <= '0;
            r_tempo  <= 7'd18;
            r_brk    <= 1'b0;
            r_flash  <= '0;
            r_led    <= 1'b1;
            r_period <= '0;
        end else begin
            r_status <= n_status;
            r_sel    <= n_sel;
            r_pos    <= n_pos;
            r_tick   <= n_tick;
            r_tempo  <= n_tempo;
            r_brk    <= n_brk;
            r_flash  <= n_flash;
            r_led    <= n_led;
            r_period <= n_period;
        end
    end

    assign o_result.period  = n_period;
    assign o_result.tone_on = (n_status == ST_PLAY);
    assign o_result.led_on  = n_led;
    assign o_result.status  = n_status;

endmodule

[src/melody_score_sequencer.sv]
// top level of the melody score sequencer: channels, configuration and result register
//
// usage:
//   input channel s_axis: one event per transfer, event code in tuser, score
//   address and byte in tdata (only used by the write-score event)
//   output channel m_axis: one result per event with the tone half-period,
//   tone enable, led level and player status after the event
//   configuration channel i_cfg_*: always ready, register index and data;
//   indexes past the last register are accepted and ignored
// timing:
//   an accepted event reads two score bytes at its transfer edge, then updates
//   the player state and loads the result register once that register is free
//   the next event is taken only after this update, since the next read address
//   depends on the updated player state
// reset:
//   player returns to ready at song a, tempo 18, led on; score memory keeps
//   its contents
// stalls:
//   a result waits in the output register; one further event is taken and
//   holds with its read data until the result register is free
module melody_score_sequencer
    import msseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] score_address, [15:8] score_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] tone_half_period, [11] tone_on,
                                        // [12] led_on, [14:13] player_status, [15] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_result r_out;
    t_result w_result;

    logic       r_s1_valid;
    logic [2:0] r_s1_op;
    logic [7:0] r_s1_addr;
    logic [7:0] r_s1_byte;
    logic       r_out_valid;

    logic                w_accept;
    logic                w_exec;
    logic [SCORE_AW-1:0] w_raddr0;
    logic [SCORE_AW-1:0] w_raddr1;
    logic [7:0]          w_rdata0;
    logic [7:0]          w_rdata1;
    logic [SCORE_AW-1:0] w_waddr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a_start   <= 8'd0;
            r_cfg.a_len     <= 9'd72;
            r_cfg.b_start   <= 8'd72;
            r_cfg.b_len     <= 9'd133;
            r_cfg.def_tempo <= 7'd18;
            r_cfg.flash_ivl <= 8'd29;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A_START:   r_cfg.a_start   <= i_cfg_data[7:0];
                CFG_A_LEN:     r_cfg.a_len     <= i_cfg_data;
                CFG_B_START:   r_cfg.b_start   <= i_cfg_data[7:0];
                CFG_B_LEN:     r_cfg.b_len     <= i_cfg_data;
                CFG_DEF_TEMPO: r_cfg.def_tempo <= i_cfg_data[6:0];
                CFG_FLASH:     r_cfg.flash_ivl <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // one event in flight: the next read address depends on its update
    assign s_axis_tready = !r_s1_valid;
    assign w_accept      = s_axis_tvalid && !r_s1_valid;
    assign w_exec        = r_s1_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_exec) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op   <= s_axis_tuser;
            r_s1_addr <= s_axis_tdata[7:0];
            r_s1_byte <= s_axis_tdata[15:8];
        end
    end

    assign w_waddr = SCORE_AW'(r_s1_addr);

    msseq_score_mem u_mem (
        .i_clk    (i_clk),
        .i_we     (w_exec && (r_s1_op == OP_WRITE)),
        .i_waddr  (w_waddr),
        .i_wdata  (r_s1_byte),
        .i_re     (w_accept),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    msseq_player u_player (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_issue_op (s_axis_tuser),
        .i_exec     (w_exec),
        .i_exec_op  (r_s1_op),
        .i_rdata0   (w_rdata0),
        .i_rdata1   (w_rdata1),
        .o_raddr0   (w_raddr0),
        .o_raddr1   (w_raddr1),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.led_on, r_out.tone_on, r_out.period};

endmodule

[src/msseq_checker.sv]
// port-level checks for the melody score sequencer, bound to the top level
module msseq_checker
    import msseq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    logic w_in_xfer;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one event at a time: no transfer right after a transfer
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("input taken in back-to-back cycles");

    // with a free result register the result shows without stalling, through the input stage and the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (!m_axis_tvalid || m_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("result missing two cycles after transfer");

    // tone enabled exactly while playing, padding bit zero
    a_tone_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11] == (m_axis_tdata[14:13] == ST_PLAY))
                          && !m_axis_tdata[15])
        else $error("tone enable does not match status");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind melody_score_sequencer msseq_checker u_msseq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

[tb/melody_score_sequencer_tb.sv]
// testbench for the melody score sequencer: directed and random events checked against a player model
module melody_score_sequencer_tb
    import msseq_pkg::*;
();

    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 90;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;

    localparam logic [10:0] TONE_TABLE [26] = '{
        11'd1,    11'd1911, 11'd1803, 11'd1703, 11'd1607, 11'd1517, 11'd1432,
        11'd1351, 11'd1276, 11'd1204, 11'd1136, 11'd1073, 11'd1012, 11'd956,
        11'd902,  11'd851,  11'd803,  11'd758,  11'd716,  11'd676,  11'd638,
        11'd602,  11'd568,  11'd536,  11'd506,  11'd478
    };
    localparam int BEAT_TABLE [8] = '{1, 8, 16, 24, 32, 48, 64, 96};

    typedef struct packed {
        logic [10:0] half_period;
        logic        tone_on;
        logic        led_on;
        logic [1:0]  status;
    } t_tone_result;

    typedef struct packed {
        logic [7:0] a_start;
        logic [8:0] a_len;
        logic [7:0] b_start;
        logic [8:0] b_len;
        logic [6:0] def_tempo;
        logic [7:0] flash_ivl;
    } t_player_cfg;

    typedef struct packed {
        logic [2:0]   op;
        logic [7:0]   addr;
        logic [7:0]   sbyte;
        logic         typed;
        t_tone_result result;
    } t_directed_row;

    localparam t_tone_result AT_RESET    = '{11'd0, 1'b0, 1'b1, ST_READY};
    localparam t_tone_result READY_NOTE1 = '{11'd1910, 1'b0, 1'b1, ST_READY};
    localparam t_tone_result PLAY_NOTE1  = '{11'd1910, 1'b1, 1'b0, ST_PLAY};
    localparam t_tone_result READY_REST  = '{11'd0, 1'b0, 1'b1, ST_READY};

    // typed results assume the reset settings: song a at 0, song b at 72, tempo 18
    localparam t_directed_row DIRECTED_ROWS [25] = '{
        '{OP_WRITE,   8'd0,   8'h01, 1'b1, AT_RESET},
        '{OP_WRITE,   8'd1,   8'h3F, 1'b0, '0},
        '{OP_WRITE,   8'd2,   8'h1A, 1'b0, '0},
        '{OP_WRITE,   8'd255, 8'hFF, 1'b0, '0},
        '{OP_WRITE,   8'd72,  8'h1A, 1'b0, '0},
        '{OP_RESTART, 8'd0,   8'h00, 1'b1, READY_NOTE1},
        '{OP_TICK,    8'd0,   8'h00, 1'b1, READY_NOTE1},
        '{OP_PLAY,    8'd0,   8'h00, 1'b1, PLAY_NOTE1},
        '{OP_TICK,    8'hFF,  8'hFF, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_SLOWER,  8'd0,   8'h00, 1'b0, '0},
        '{OP_FASTER,  8'd0,   8'h00, 1'b0, '0},
        '{OP_PLAY,    8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_PLAY,    8'd0,   8'h00, 1'b0, '0},
        '{OP_SONG_B,  8'd0,   8'h00, 1'b1, READY_REST},
        '{OP_PLAY,    8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_SONG_A,  8'd0,   8'h00, 1'b1, READY_NOTE1},
        '{OP_WRITE,   8'd0,   8'h00, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'h00, 1'b0, '0},
        '{OP_FASTER,  8'd0,   8'h00, 1'b0, '0}
    };

    // fixed settings for the first phases: address wrap, empty song, out-of-range tempos
    localparam t_player_cfg CFG_SWEEP [4] = '{
        '{8'd250, 9'd10,  8'd5,   9'd3,   7'd1,   8'd0},
        '{8'd0,   9'd0,   8'd255, 9'd1,   7'd88,  8'd255},
        '{8'd17,  9'd256, 8'd128, 9'd2,   7'd0,   8'd3},
        '{8'd255, 9'd5,   8'd0,   9'd511, 7'd127, 8'd128}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [7:0] score_address, [15:8] score_byte
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [10:0] tone_half_period, [11] tone_on, [12] led_on,
                                       // [14:13] player_status, [15] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [8:0]  i_cfg_data    = '0;

    // player model state
    logic [7:0]  score_copy [256];
    t_player_cfg cfg_copy;
    logic [1:0]  st;
    logic        song_b;
    logic [8:0]  pos;
    logic [10:0] tick_cnt;
    logic [6:0]  tempo;
    logic        brk;
    logic [7:0]  flash_cnt;
    logic        led;
    logic [10:0] half_period;

    t_tone_result expected_tones [$];
    logic         row_typed = 1'b0;
    t_tone_result row_result = '0;
    int           fail_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_ask = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    melody_score_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [10:0] tone_of(input logic [7:0] b);
        if (int'(b[4:0]) >= NOTE_COUNT || b[4:0] >= 5'd26) begin
            return 11'd1;
        end
        return TONE_TABLE[b[4:0]];
    endfunction

    function automatic logic [8:0] song_length();
        return song_b ? cfg_copy.b_len : cfg_copy.a_len;
    endfunction

    function automatic logic [7:0] score_byte_at(input logic [8:0] p);
        logic [7:0] addr;
        addr = (song_b ? cfg_copy.b_start : cfg_copy.a_start) + p[7:0];
        return score_copy[addr];
    endfunction

    function automatic t_tone_result current_tone();
        t_tone_result r;
        r.half_period = half_period;
        r.tone_on     = (st == ST_PLAY);
        r.led_on      = led;
        r.status      = st;
        return r;
    endfunction

    task automatic player_reset();
        cfg_copy  = '{8'd0, 9'd72, 8'd72, 9'd133, 7'd18, 8'd29};
        st        = ST_READY;
        song_b    = 1'b0;
        pos       = '0;
        tick_cnt  = '0;
        tempo     = 7'd18;
        brk       = 1'b0;
        flash_cnt = '0;
        led       = 1'b1;
        half_period = '0;
    endtask

    task automatic player_restart();
        tick_cnt    = '0;
        pos         = '0;
        tempo       = cfg_copy.def_tempo;
        brk         = 1'b0;
        st          = ST_READY;
        // the first note is loaded one count short
        half_period = tone_of(score_byte_at(9'd0)) - 11'd1;
        led         = 1'b1;
    endtask

    task automatic player_advance(input logic set_brk);
        logic [7:0] b;
        tick_cnt = '0;
        pos      = pos + 9'd1;
        if (pos < song_length()) begin
            b           = score_byte_at(pos);
            half_period = tone_of(b);
            brk         = set_brk && (b[7:5] == 3'd0);
        end else begin
            // stepped past the end: keep the tone, no lookup
            brk = 1'b0;
        end
    endtask

    task automatic player_tick();
        int beats;
        if (st == ST_PLAY) begin
            if (pos < song_length()) begin
                if (!brk) begin
                    beats = BEAT_TABLE[score_byte_at(pos) >> 5];
                    if (int'(tick_cnt) * 8 >= beats * int'(tempo)) begin
                        player_advance(1'b1);
                    end else if (tick_cnt < 11'd2047) begin
                        tick_cnt = tick_cnt + 11'd1;
                    end
                end else begin
                    player_advance(1'b0);
                end
            end else begin
                st  = ST_DONE;
                led = 1'b1;
            end
        end else if (st == ST_PAUSE) begin
            if (flash_cnt == cfg_copy.flash_ivl) begin
                flash_cnt = '0;
                led       = ~led;
            end else begin
                flash_cnt = flash_cnt + 8'd1;
            end
        end
    endtask

    task automatic play_event(input logic [2:0] op, input logic [7:0] addr,
                              input logic [7:0] sbyte);
        case (op)
            OP_TICK:    player_tick();
            OP_RESTART: player_restart();
            OP_PLAY: begin
                if (st != ST_DONE) begin
                    st = (st == ST_PLAY) ? ST_PAUSE : ST_PLAY;
                    if (st == ST_PLAY) begin
                        led = 1'b0;
                    end
                end
            end
            OP_SLOWER: begin
                if (tempo < TEMPO_MAX) begin
                    tempo = tempo + 7'd1;
                end
            end
            OP_FASTER: begin
                if (tempo > TEMPO_MIN) begin
                    tempo = tempo - 7'd1;
                end
            end
            OP_SONG_A: begin
                song_b = 1'b0;
                player_restart();
            end
            OP_SONG_B: begin
                song_b = 1'b1;
                player_restart();
            end
            default: score_copy[addr] = sbyte;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side first so a result is never matched with the event taken at the same edge
    always @(posedge i_clk) begin : tone_monitor
        t_tone_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_tones.size() == 0) begin
                $error("result transfer with no event outstanding, tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_tones.pop_front();
                check_field("tone_half_period", want.half_period, m_axis_tdata[10:0]);
                check_field("tone_on", want.tone_on, m_axis_tdata[11]);
                check_field("led_on", want.led_on, m_axis_tdata[12]);
                check_field("player_status", want.status, m_axis_tdata[14:13]);
                check_field("tdata pad", 0, m_axis_tdata[15]);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            play_event(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (row_typed) begin
                expected_tones.push_back(row_result);
            end else begin
                expected_tones.push_back(current_tone());
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_event(input logic [2:0] op, input logic [7:0] addr,
                              input logic [7:0] sbyte);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {sbyte, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (expected_tones.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [8:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_A_START:   cfg_copy.a_start   = data[7:0];
            CFG_A_LEN:     cfg_copy.a_len     = data;
            CFG_B_START:   cfg_copy.b_start   = data[7:0];
            CFG_B_LEN:     cfg_copy.b_len     = data;
            CFG_DEF_TEMPO: cfg_copy.def_tempo = data[6:0];
            CFG_FLASH:     cfg_copy.flash_ivl = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input t_player_cfg c);
        cfg_write(CFG_A_START, {1'b0, c.a_start});
        cfg_write(CFG_A_LEN, c.a_len);
        cfg_write(CFG_B_START, {1'b0, c.b_start});
        cfg_write(CFG_B_LEN, c.b_len);
        cfg_write(CFG_DEF_TEMPO, {2'b00, c.def_tempo});
        cfg_write(CFG_FLASH, {1'b0, c.flash_ivl});
        // unused index must be ignored
        cfg_write(CFG_UNUSED, 9'($urandom_range(0, 511)));
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        logic [2:0]  op;
        logic [7:0]  addr;
        logic [7:0]  sbyte;
        int          r;
        logic        play_next;
        t_player_cfg next_cfg;

        player_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill the whole score so no event ever reads an empty entry
        for (int a = 0; a < 256; a++) begin
            sbyte = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0) begin
                sbyte[7:5] = 3'($urandom_range(0, 2));
            end
            send_event(OP_WRITE, a[7:0], sbyte);
        end

        for (int n = 0; n < 25; n++) begin
            row_typed  = DIRECTED_ROWS[n].typed;
            row_result = DIRECTED_ROWS[n].result;
            send_event(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].addr, DIRECTED_ROWS[n].sbyte);
        end
        row_typed = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph < 4) begin
                next_cfg = CFG_SWEEP[ph];
            end else begin
                next_cfg.a_start   = 8'($urandom_range(0, 255));
                next_cfg.a_len     = 9'($urandom_range(0, 24));
                next_cfg.b_start   = 8'($urandom_range(0, 255));
                next_cfg.b_len     = 9'($urandom_range(0, 40));
                next_cfg.def_tempo = 7'($urandom_range(1, 24));
                next_cfg.flash_ivl = 8'($urandom_range(0, 10));
            end
            set_config(next_cfg);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            play_next = 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 40) begin
                    // long output stall while events keep coming
                    hold_ask++;
                end
                if (ph == 1 && k == 60) begin
                    s_axis_tvalid = 1'b0;
                    while (expected_tones.size() != 0) @(negedge i_clk);
                end
                addr  = 8'($urandom_range(0, 255));
                sbyte = 8'($urandom_range(0, 255));
                if (play_next) begin
                    op        = OP_PLAY;
                    play_next = 1'b0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 52)      op = OP_TICK;
                    else if (r < 60) op = OP_PLAY;
                    else if (r < 66) op = OP_SLOWER;
                    else if (r < 72) op = OP_FASTER;
                    else if (r < 76) op = OP_RESTART;
                    else if (r < 80) op = OP_SONG_A;
                    else if (r < 84) op = OP_SONG_B;
                    else             op = OP_WRITE;
                    if (op == OP_RESTART || op == OP_SONG_A || op == OP_SONG_B) begin
                        play_next = ($urandom_range(0, 4) != 0);
                    end
                end
                // keep most written notes short so songs move along
                if (op == OP_WRITE && $urandom_range(0, 9) < 7) begin
                    sbyte[7:5] = 3'($urandom_range(0, 2));
                end
                send_event(op, addr, sbyte);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[melody_score_sequencer.f]
src/msseq_pkg.sv
src/msseq_score_mem.sv
src/msseq_player.sv
src/melody_score_sequencer.sv
src/msseq_checker.sv
tb/melody_score_sequencer_tb.sv
